@@ hdl/triangle_barycentric_weights_core_assert.svh @@
// Assertion macros for the barycentric weights core.
// Used by the top level; no other dependencies.
`ifndef TRIANGLE_BARYCENTRIC_WEIGHTS_CORE_ASSERT_SVH
`define TRIANGLE_BARYCENTRIC_WEIGHTS_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// cond must never hold
`define TBW_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
// ante implies cons in the same cycle
`define TBW_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`else
`define TBW_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`define TBW_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

@@ hdl/tbw_pkg.sv @@
// Shared widths, codes and types of the barycentric weights core.
// No dependencies.
`default_nettype none
package tbw_pkg;
	localparam int COORD_W    = 16;
	localparam int FRAC_W     = 16;
	localparam int WEIGHT_W   = FRAC_W + 4;
	localparam int THRESH_W   = 20;
	localparam int CLAMP_BITS = 40;
	localparam int EDGE_W     = COORD_W + 1;
	localparam int PROD_W     = 2 * EDGE_W;
	localparam int SUM_W      = PROD_W + 1;
	localparam int MAG_W      = SUM_W;
	localparam int QUOT_W     = CLAMP_BITS;
	localparam int PRE_W      = CLAMP_BITS - FRAC_W;
	localparam int QS_W       = CLAMP_BITS + 2;
	localparam int CALC_W     = QS_W + 2;
	localparam int Q_DEPTH    = 4;
	localparam int Q_AW       = 2;

	typedef enum logic [1:0] {
		KIND_PROPER  = 2'd0,
		KIND_SEGMENT = 2'd1,
		KIND_POINT   = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [1:0] best;
	} tbw_tag_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] num_a;
		logic signed [SUM_W-1:0] den_a;
		logic signed [SUM_W-1:0] num_b;
		logic signed [SUM_W-1:0] den_b;
		tbw_tag_t                tag;
	} tbw_job_t;
endpackage
`default_nettype wire

@@ hdl/tbw_in_if.sv @@
// Input channel: triangle vertices and query point with valid/ready.
// Depends on tbw_pkg.
`default_nettype none
interface tbw_in_if import tbw_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] vertex0_x;
	logic signed [COORD_W-1:0] vertex0_y;
	logic signed [COORD_W-1:0] vertex1_x;
	logic signed [COORD_W-1:0] vertex1_y;
	logic signed [COORD_W-1:0] vertex2_x;
	logic signed [COORD_W-1:0] vertex2_y;
	logic signed [COORD_W-1:0] point_x;
	logic signed [COORD_W-1:0] point_y;
	modport source (output valid, vertex0_x, vertex0_y, vertex1_x, vertex1_y,
		vertex2_x, vertex2_y, point_x, point_y, input ready);
	modport sink (input valid, vertex0_x, vertex0_y, vertex1_x, vertex1_y,
		vertex2_x, vertex2_y, point_x, point_y, output ready);
endinterface
`default_nettype wire

@@ hdl/tbw_out_if.sv @@
// Output channel: three weights, case kind and saturation flag.
// Depends on tbw_pkg.
`default_nettype none
interface tbw_out_if import tbw_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [WEIGHT_W-1:0] weight0;
	logic signed [WEIGHT_W-1:0] weight1;
	logic signed [WEIGHT_W-1:0] weight2;
	logic [1:0]                 case_kind;
	logic                       saturated;
	modport source (output valid, weight0, weight1, weight2, case_kind, saturated,
		input ready);
	modport sink (input valid, weight0, weight1, weight2, case_kind, saturated,
		output ready);
endinterface
`default_nettype wire

@@ hdl/tbw_front.sv @@
// Front end: edges, products, determinants and classification into jobs.
// Depends on tbw_pkg and tbw_in_if.
`default_nettype none
module tbw_front import tbw_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [THRESH_W-1:0] thresh,
	tbw_in_if.sink              req,
	input  logic                q_full,
	output logic                q_push,
	output tbw_job_t            q_job
);
	logic fe;
	logic v_s1, v_s2, v_s3;
	logic signed [COORD_W-1:0] vx [3];
	logic signed [COORD_W-1:0] vy [3];
	logic signed [EDGE_W-1:0] ex_s1 [3];
	logic signed [EDGE_W-1:0] ey_s1 [3];
	logic signed [EDGE_W-1:0] dx_s1 [3];
	logic signed [EDGE_W-1:0] dy_s1 [3];
	logic signed [PROD_W-1:0] cra_s2 [3];
	logic signed [PROD_W-1:0] crb_s2 [3];
	logic signed [PROD_W-1:0] sqx_s2 [3];
	logic signed [PROD_W-1:0] sqy_s2 [3];
	logic signed [PROD_W-1:0] dpx_s2 [3];
	logic signed [PROD_W-1:0] dpy_s2 [3];
	logic signed [SUM_W-1:0]  cr_s3 [3];
	logic signed [SUM_W-1:0]  len_s3 [3];
	logic signed [SUM_W-1:0]  dp_s3 [3];
	logic [SUM_W-1:0] aden, best_len;
	logic [1:0]       best;

	assign fe = !(v_s3 && q_full);
	assign req.ready = fe;
	assign q_push = v_s3 && !q_full;

	assign vx[0] = req.vertex0_x;
	assign vy[0] = req.vertex0_y;
	assign vx[1] = req.vertex1_x;
	assign vy[1] = req.vertex1_y;
	assign vx[2] = req.vertex2_x;
	assign vy[2] = req.vertex2_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (fe) begin
			v_s1 <= req.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// edges e_k = v_(k+1) - v_k, offsets p - v_k
	always_ff @(posedge clk) begin
		if (fe) begin
			for (int k = 0; k < 3; k++) begin
				ex_s1[k] <= EDGE_W'(vx[(k + 1) % 3]) - EDGE_W'(vx[k]);
				ey_s1[k] <= EDGE_W'(vy[(k + 1) % 3]) - EDGE_W'(vy[k]);
				dx_s1[k] <= EDGE_W'(req.point_x) - EDGE_W'(vx[k]);
				dy_s1[k] <= EDGE_W'(req.point_y) - EDGE_W'(vy[k]);
			end
		end
	end

	// cross terms: 0 area, 1 weight0 numerator, 2 weight2 numerator
	always_ff @(posedge clk) begin
		if (fe) begin
			cra_s2[0] <= PROD_W'(ex_s1[0] * ey_s1[1]);
			crb_s2[0] <= PROD_W'(ey_s1[0] * ex_s1[1]);
			cra_s2[1] <= PROD_W'(ex_s1[1] * dy_s1[1]);
			crb_s2[1] <= PROD_W'(ey_s1[1] * dx_s1[1]);
			cra_s2[2] <= PROD_W'(ex_s1[0] * dy_s1[0]);
			crb_s2[2] <= PROD_W'(ey_s1[0] * dx_s1[0]);
			for (int k = 0; k < 3; k++) begin
				sqx_s2[k] <= PROD_W'(ex_s1[k] * ex_s1[k]);
				sqy_s2[k] <= PROD_W'(ey_s1[k] * ey_s1[k]);
				dpx_s2[k] <= PROD_W'(dx_s1[k] * ex_s1[k]);
				dpy_s2[k] <= PROD_W'(dy_s1[k] * ey_s1[k]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fe) begin
			for (int k = 0; k < 3; k++) begin
				cr_s3[k]  <= SUM_W'(cra_s2[k]) - SUM_W'(crb_s2[k]);
				len_s3[k] <= SUM_W'(sqx_s2[k]) + SUM_W'(sqy_s2[k]);
				dp_s3[k]  <= SUM_W'(dpx_s2[k]) + SUM_W'(dpy_s2[k]);
			end
		end
	end

	// classify; longest edge wins, first on ties
	always_comb begin
		aden = cr_s3[0][SUM_W-1] ? SUM_W'(-cr_s3[0]) : SUM_W'(cr_s3[0]);
		best_len = '0;
		best = 2'd0;
		for (int k = 0; k < 3; k++) begin
			if ($unsigned(len_s3[k]) > best_len) begin
				best_len = $unsigned(len_s3[k]);
				best = 2'(k);
			end
		end
		q_job.tag.best = best;
		if (aden > SUM_W'(thresh)) begin
			q_job.num_a = cr_s3[1];
			q_job.den_a = cr_s3[0];
			q_job.num_b = cr_s3[2];
			q_job.den_b = cr_s3[0];
			q_job.tag.kind = KIND_PROPER;
		end else begin
			q_job.num_a = dp_s3[best];
			q_job.den_a = $signed(best_len);
			q_job.num_b = '0;
			q_job.den_b = SUM_W'(1);
			q_job.tag.kind = KIND_SEGMENT;
			if (best_len == '0) begin
				q_job.den_a = SUM_W'(1);
				q_job.tag.kind = KIND_POINT;
			end
		end
	end
endmodule
`default_nettype wire

@@ hdl/tbw_queue.sv @@
// Short job queue between front and back ends.
// Depends on tbw_pkg.
`default_nettype none
module tbw_queue import tbw_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  tbw_job_t push_job,
	input  logic     pop,
	output logic     full,
	output logic     empty,
	output tbw_job_t head
);
	tbw_job_t        mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [Q_AW:0]   cnt_q;

	assign full  = cnt_q == (Q_AW + 1)'(Q_DEPTH);
	assign empty = cnt_q == '0;
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_job;
	end
endmodule
`default_nettype wire

@@ hdl/tbw_div.sv @@
// Pipelined restoring divider: trunc(num * 2^F / den), magnitude clamped.
// One quotient bit per stage. Depends on tbw_pkg.
`default_nettype none
module tbw_div import tbw_pkg::*; (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [SUM_W-1:0] num,
	input  logic signed [SUM_W-1:0] den,
	output logic signed [QS_W-1:0]  quo
);
	logic [MAG_W-1:0]  rem_s [QUOT_W+1];
	logic [MAG_W-1:0]  dvs_s [QUOT_W+1];
	logic [QUOT_W-1:0] low_s [QUOT_W+1];
	logic [QUOT_W-1:0] q_s   [QUOT_W+1];
	logic              neg_s [QUOT_W+1];
	logic              clamp_s [QUOT_W+1];
	logic [MAG_W-1:0]  a_mag, b_mag;
	logic [QUOT_W:0]   mag;

	assign a_mag = num[SUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
	assign b_mag = den[SUM_W-1] ? MAG_W'(-den) : MAG_W'(den);

	// integer part at or above 2^PRE_W means clamp; else remainder starts at a >> PRE_W
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]   <= a_mag >> PRE_W;
			dvs_s[0]   <= b_mag;
			low_s[0]   <= {a_mag[PRE_W-1:0], {FRAC_W{1'b0}}};
			q_s[0]     <= '0;
			neg_s[0]   <= num[SUM_W-1] ^ den[SUM_W-1];
			clamp_s[0] <= (a_mag >> PRE_W) >= b_mag;
		end
	end

	for (genvar i = 1; i <= QUOT_W; i++) begin : g_step
		logic [MAG_W:0] trial;
		logic           ge;
		assign trial = {rem_s[i-1], low_s[i-1][QUOT_W-1]};
		assign ge = trial >= {1'b0, dvs_s[i-1]};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i]   <= ge ? MAG_W'(trial - {1'b0, dvs_s[i-1]}) : MAG_W'(trial);
				dvs_s[i]   <= dvs_s[i-1];
				low_s[i]   <= {low_s[i-1][QUOT_W-2:0], 1'b0};
				q_s[i]     <= {q_s[i-1][QUOT_W-2:0], ge};
				neg_s[i]   <= neg_s[i-1];
				clamp_s[i] <= clamp_s[i-1];
			end
		end
	end

	assign mag = clamp_s[QUOT_W] ? {1'b1, {QUOT_W{1'b0}}} : {1'b0, q_s[QUOT_W]};
	assign quo = neg_s[QUOT_W] ? -$signed(QS_W'(mag)) : $signed(QS_W'(mag));
endmodule
`default_nettype wire

@@ hdl/tbw_back.sv @@
// Back end: two divider lanes, weight assembly, saturation, output register.
// Depends on tbw_pkg, tbw_div and tbw_out_if.
`default_nettype none
module tbw_back import tbw_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     q_empty,
	input  tbw_job_t q_head,
	output logic     q_pop,
	tbw_out_if.source rsp
);
	logic                     be;
	logic                     v_s   [QUOT_W+1];
	tbw_tag_t                 tag_s [QUOT_W+1];
	logic signed [QS_W-1:0]   qa, qb;
	logic signed [CALC_W-1:0] w [3];
	logic signed [CALC_W-1:0] ta, tb, one, hi, lo;
	logic signed [WEIGHT_W-1:0] ws [3];
	logic                     clip;
	logic [1:0]               nx;

	assign be    = !(rsp.valid && !rsp.ready);
	assign q_pop = be && !q_empty;

	tbw_div u_div_a (.clk(clk), .en(be), .num(q_head.num_a), .den(q_head.den_a), .quo(qa));
	tbw_div u_div_b (.clk(clk), .en(be), .num(q_head.num_b), .den(q_head.den_b), .quo(qb));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= QUOT_W; i++) v_s[i] <= 1'b0;
			rsp.valid <= 1'b0;
		end else if (be) begin
			v_s[0] <= !q_empty;
			for (int i = 1; i <= QUOT_W; i++) v_s[i] <= v_s[i-1];
			rsp.valid <= v_s[QUOT_W];
		end
	end

	always_ff @(posedge clk) begin
		if (be) begin
			tag_s[0] <= q_head.tag;
			for (int i = 1; i <= QUOT_W; i++) tag_s[i] <= tag_s[i-1];
		end
	end

	always_comb begin
		ta  = CALC_W'(qa);
		tb  = CALC_W'(qb);
		one = CALC_W'(1) <<< FRAC_W;
		hi  = (CALC_W'(1) <<< (WEIGHT_W - 1)) - CALC_W'(1);
		lo  = -hi - CALC_W'(1);
		nx  = (tag_s[QUOT_W].best == 2'd2) ? 2'd0 : tag_s[QUOT_W].best + 2'd1;
		for (int k = 0; k < 3; k++) w[k] = '0;
		case (tag_s[QUOT_W].kind)
			KIND_PROPER: begin
				w[0] = ta;
				w[1] = one - ta - tb;
				w[2] = tb;
			end
			KIND_SEGMENT: begin
				w[nx] = ta;
				w[tag_s[QUOT_W].best] = one - ta;
			end
			default: begin
			end
		endcase
		clip = 1'b0;
		for (int k = 0; k < 3; k++) begin
			if (w[k] > hi) begin
				ws[k] = WEIGHT_W'(hi);
				clip = 1'b1;
			end else if (w[k] < lo) begin
				ws[k] = WEIGHT_W'(lo);
				clip = 1'b1;
			end else begin
				ws[k] = WEIGHT_W'(w[k]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (be) begin
			rsp.weight0   <= ws[0];
			rsp.weight1   <= ws[1];
			rsp.weight2   <= ws[2];
			rsp.case_kind <= tag_s[QUOT_W].kind;
			rsp.saturated <= clip;
		end
	end
endmodule
`default_nettype wire

@@ hdl/triangle_barycentric_weights_core.sv @@
// Top level of the barycentric weights core: threshold register, front end,
// job queue and back end. Depends on tbw_pkg, the channel interfaces and all tbw_ modules.
//
// Usage
//   req carries one triangle (three vertices) and a query point per transfer;
//   rsp carries weight0..2 (signed Q3.16), case_kind and saturated per transfer.
//   cfg_we/cfg_wdata write degenerate_threshold; write only while idle.
// Throughput: one transfer per cycle on each side, sustained while rsp is ready.
// Path: an input passes 3 front stages (edges, products, determinants with
//   classification), the job queue, 41 divider stages incl. load and 1 output
//   reg before rsp.valid rises; a stall can hold any of these stages.
//   The 40-stage restoring divider computes one quotient bit a stage.
// Stall: when rsp is valid and not ready the back end freezes in place; the front end
//   keeps taking transfers until the 4-entry job queue fills, then drops ready.
// Reset: arst_n clears all valid flags, queue pointers and the threshold (0).
//
`default_nettype none
`include "triangle_barycentric_weights_core_assert.svh"
module triangle_barycentric_weights_core import tbw_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [THRESH_W-1:0] cfg_wdata,
	tbw_in_if.sink              req,
	tbw_out_if.source           rsp
);
	logic [THRESH_W-1:0] thresh_q;
	logic     q_push, q_pop, q_full, q_empty;
	tbw_job_t push_job, head_job;

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) thresh_q <= '0;
		else if (cfg_we) thresh_q <= cfg_wdata;
	end

	// front: edges, products, determinants, classification
	tbw_front u_front (
		.clk(clk), .arst_n(arst_n), .thresh(thresh_q), .req(req),
		.q_full(q_full), .q_push(q_push), .q_job(push_job)
	);

	// decoupling queue
	tbw_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(q_push), .push_job(push_job),
		.pop(q_pop), .full(q_full), .empty(q_empty), .head(head_job)
	);

	// back: division lanes and weight assembly
	tbw_back u_back (
		.clk(clk), .arst_n(arst_n), .q_empty(q_empty), .q_head(head_job),
		.q_pop(q_pop), .rsp(rsp)
	);

	`TBW_ASSERT_NEVER(a_q_overflow, clk, arst_n, q_push && q_full, "queue overflow")
	`TBW_ASSERT_NEVER(a_q_underflow, clk, arst_n, q_pop && q_empty, "queue underflow")
	`TBW_ASSERT_IMPLY(a_point_zero, clk, arst_n, rsp.valid && rsp.case_kind == KIND_POINT,
		rsp.weight0 == '0 && rsp.weight1 == '0 && rsp.weight2 == '0 && !rsp.saturated,
		"point case with nonzero weights")
endmodule
`default_nettype wire
